FILE: rtl/bba_pkg.sv
// shared constants and codes for the buddy block allocator
package bba_pkg;

	localparam int MAX_ORDER_C  = 20;
	localparam int MAX_SPAN_C   = 10;
	localparam int MAX_OWNERS_C = 64;

	localparam int CFG_W   = 5;
	localparam int ID_W    = 6;
	localparam int SIZE_W  = 21;
	localparam int OFF_W   = 20;
	localparam int BORD_W  = 5;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [CFG_W-1:0] UPPER_RST = 5'd20;
	localparam logic [CFG_W-1:0] LOWER_RST = 5'd10;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_TOO_BIG   = 3'd2,
		ST_NOT_ALLOC = 3'd3,
		ST_ALREADY   = 3'd4
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic {
		REG_UPPER = 1'b0,
		REG_LOWER = 1'b1
	} reg_sel_t;

endpackage

FILE: rtl/buddy_block_allocator_top.sv
// buddy block allocator top level: request sequencer over link, tag and owner memories
// a split steps through S_SPL0 and S_PUSH for each order, a merge through S_FTAG, S_FCMP and
// S_FRM for each order, and the free-list search stays in S_SRCH for each order it tries
// throughput: one request at a time; the next request is taken once the result is registered
// reset and every configuration write start a clearing pass over the tag memory, during which
// no request is taken; all owners become invalid at once
module buddy_block_allocator_top #(
	parameter int MAX_ORDER  = bba_pkg::MAX_ORDER_C,
	parameter int MAX_SPAN   = bba_pkg::MAX_SPAN_C,
	parameter int MAX_OWNERS = bba_pkg::MAX_OWNERS_C
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bba_pkg::ADDR_W-1:0]  paddr,
	input  logic [bba_pkg::DATA_W-1:0]  pwdata,
	output logic [bba_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [bba_pkg::ID_W-1:0]    owner_id,
	input  logic [bba_pkg::SIZE_W-1:0]  request_size,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [bba_pkg::OFF_W-1:0]   block_offset,
	output logic [bba_pkg::BORD_W-1:0]  block_order
);
	import bba_pkg::*;

	localparam int UNIT_W = MAX_SPAN;
	localparam int NUNITS = 1 << MAX_SPAN;
	localparam int LINK_W = MAX_SPAN + 1;
	localparam int ORD_W  = $clog2(MAX_ORDER + 2);
	localparam int REL_W  = $clog2(MAX_SPAN + 1);
	localparam int TAG_W  = REL_W + 1;
	localparam int OID_W  = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
	localparam int OWN_W  = REL_W + UNIT_W;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(NUNITS);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_SRCH, S_ARM, S_SPL0, S_PUSH, S_AFIN,
		S_FOWN, S_FTAG, S_FCMP, S_FRM, S_FFIN0, S_RES
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]  upper_q, lower_q;
	logic              clr_q;
	logic [UNIT_W-1:0] clr_cnt_q;
	logic [LINK_W-1:0] head_q [MAX_ORDER+1];
	logic              own_vld_q [MAX_OWNERS];

	logic              mode_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] size_q;
	logic [ORD_W-1:0]  j_q, k_q;
	logic [UNIT_W-1:0] b_q, bud_q, r_q;
	logic [LINK_W-1:0] h_q;
	status_t           res_st_q;
	logic [OFF_W-1:0]  res_off_q;
	logic [BORD_W-1:0] res_ord_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [OFF_W-1:0]  offset_q;
	logic [BORD_W-1:0] order_q;

	logic [LINK_W-1:0] next_mem [NUNITS];
	logic [LINK_W-1:0] prev_mem [NUNITS];
	logic [TAG_W-1:0]  tag_mem  [NUNITS];
	logic [OWN_W-1:0]  own_mem  [MAX_OWNERS];
	logic [LINK_W-1:0] nx_rd_q, pv_rd_q;
	logic [TAG_W-1:0]  tag_rd_q;
	logic [OWN_W-1:0]  own_rd_q;

	logic              nx_we, pv_we, tag_we, own_we;
	logic [UNIT_W-1:0] nx_wa, pv_wa, tag_wa, lnk_ra, tag_ra;
	logic [LINK_W-1:0] nx_wd, pv_wd;
	logic [TAG_W-1:0]  tag_wd;
	logic [OWN_W-1:0]  own_wd;

	logic [ORD_W-1:0]  eff_u, eff_l, k_c, jm1;
	logic [5:0]        k_full;
	logic [REL_W-1:0]  rel_j, rel_jm1, rel_k, rel_u;
	logic [UNIT_W-1:0] r_c, bud_c;
	logic [LINK_W-1:0] head_j, head_jm1;
	logic [OID_W-1:0]  oidx;
	logic              id_ok, cfg_wr;

	function automatic logic [OFF_W-1:0] unit_off(input logic [UNIT_W-1:0] u,
			input logic [ORD_W-1:0] sh);
		logic [63:0] w;
		w = 64'(u) << sh;
		return w[OFF_W-1:0];
	endfunction

	// effective pool geometry
	always_comb begin
		int u, l;
		u = (int'(upper_q) > MAX_ORDER) ? MAX_ORDER : int'(upper_q);
		l = int'(lower_q);
		if (u > MAX_SPAN && l < u - MAX_SPAN) begin
			l = u - MAX_SPAN;
		end
		if (l > u) begin
			l = u;
		end
		eff_u = ORD_W'(u);
		eff_l = ORD_W'(l);
	end

	// rounded order of the request size
	always_comb begin
		logic [5:0] k0;
		k0 = 6'd21;
		for (int i = SIZE_W; i >= 0; i--) begin
			if (((SIZE_W+1)'(1) << i) >= {1'b0, size_q}) begin
				k0 = 6'(i);
			end
		end
		k_full = (k0 > 6'(eff_l)) ? k0 : 6'(eff_l);
		k_c    = ORD_W'(k_full);
	end

	assign cfg_wr   = psel && penable && pwrite;
	assign oidx     = OID_W'(id_q);
	assign id_ok    = 32'(id_q) < MAX_OWNERS;
	assign jm1      = j_q - ORD_W'(1);
	assign rel_j    = REL_W'(j_q - eff_l);
	assign rel_jm1  = REL_W'(jm1 - eff_l);
	assign rel_k    = REL_W'(k_q - eff_l);
	assign rel_u    = REL_W'(eff_u - eff_l);
	assign r_c      = b_q + (UNIT_W'(1) << rel_jm1);
	assign bud_c    = b_q ^ (UNIT_W'(1) << rel_j);
	assign head_j   = (32'(j_q) <= MAX_ORDER) ? head_q[j_q] : NIL;
	assign head_jm1 = (32'(jm1) <= MAX_ORDER) ? head_q[jm1] : NIL;

	// memory port control
	always_comb begin
		nx_we  = 1'b0;
		pv_we  = 1'b0;
		tag_we = 1'b0;
		own_we = 1'b0;
		nx_wa  = b_q;
		pv_wa  = b_q;
		tag_wa = b_q;
		nx_wd  = NIL;
		pv_wd  = NIL;
		tag_wd = '0;
		own_wd = {rel_k, b_q};
		lnk_ra = (state_q == S_SRCH) ? head_j[UNIT_W-1:0] : bud_q;
		tag_ra = (state_q == S_FTAG) ? bud_c : bud_q;
		if (clr_q) begin
			tag_we = 1'b1;
			tag_wa = clr_cnt_q;
			tag_wd = (clr_cnt_q == '0) ? {1'b1, rel_u} : '0;
			nx_we  = (clr_cnt_q == '0);
			pv_we  = (clr_cnt_q == '0);
			nx_wa  = '0;
			pv_wa  = '0;
		end else begin
			case (state_q)
				S_ARM, S_FRM: begin
					if (pv_rd_q != NIL) begin
						nx_we = 1'b1;
						nx_wa = pv_rd_q[UNIT_W-1:0];
						nx_wd = nx_rd_q;
					end
					if (nx_rd_q != NIL) begin
						pv_we = 1'b1;
						pv_wa = nx_rd_q[UNIT_W-1:0];
						pv_wd = pv_rd_q;
					end
					if (state_q == S_FRM) begin
						tag_we = 1'b1;
						tag_wa = (bud_q > b_q) ? bud_q : b_q;
					end
				end
				S_SPL0: begin
					tag_we = 1'b1;
					tag_wa = r_c;
					tag_wd = {1'b1, rel_jm1};
					nx_we  = 1'b1;
					nx_wa  = r_c;
					nx_wd  = head_jm1;
					pv_we  = 1'b1;
					pv_wa  = r_c;
				end
				S_FFIN0: begin
					tag_we = 1'b1;
					tag_wd = {1'b1, rel_j};
					nx_we  = 1'b1;
					nx_wd  = head_j;
					pv_we  = 1'b1;
				end
				S_PUSH: begin
					if (h_q != NIL) begin
						pv_we = 1'b1;
						pv_wa = h_q[UNIT_W-1:0];
						pv_wd = LINK_W'(r_q);
					end
				end
				S_AFIN: begin
					tag_we = 1'b1;
					tag_wd = {1'b0, rel_k};
					own_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		nx_rd_q <= next_mem[lnk_ra];
		pv_rd_q <= prev_mem[lnk_ra];
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		tag_rd_q <= tag_mem[tag_ra];
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			own_mem[oidx] <= own_wd;
		end
		own_rd_q <= own_mem[oidx];
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			upper_q     <= UPPER_RST;
			lower_q     <= LOWER_RST;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= MAX_ORDER; i++) begin
				head_q[i] <= NIL;
			end
			for (int i = 0; i < MAX_OWNERS; i++) begin
				own_vld_q[i] <= 1'b0;
			end
		end else begin
			if (out_valid_q && !out_stall && state_q != S_RES) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (reg_sel_t'(paddr[2]) == REG_LOWER) begin
					lower_q <= pwdata[CFG_W-1:0];
				end else begin
					upper_q <= pwdata[CFG_W-1:0];
				end
				clr_q     <= 1'b1;
				clr_cnt_q <= '0;
				for (int i = 0; i < MAX_OWNERS; i++) begin
					own_vld_q[i] <= 1'b0;
				end
			end else if (clr_q) begin
				for (int i = 0; i <= MAX_ORDER; i++) begin
					head_q[i] <= (i == int'(eff_u)) ? '0 : NIL;
				end
				clr_cnt_q <= clr_cnt_q + UNIT_W'(1);
				if (clr_cnt_q == UNIT_W'(NUNITS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !clr_q) begin
						mode_q  <= mode;
						id_q    <= owner_id;
						size_q  <= request_size;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_off_q <= '0;
					res_ord_q <= '0;
					if (!id_ok) begin
						res_st_q <= ST_NOT_ALLOC;
						state_q  <= S_RES;
					end else if (mode_t'(mode_q) == MODE_ALLOC) begin
						if (own_vld_q[oidx]) begin
							res_st_q <= ST_ALREADY;
							state_q  <= S_RES;
						end else if (k_full > 6'(eff_u)) begin
							res_st_q <= ST_TOO_BIG;
							state_q  <= S_RES;
						end else begin
							j_q     <= k_c;
							k_q     <= k_c;
							state_q <= S_SRCH;
						end
					end else begin
						if (!own_vld_q[oidx]) begin
							res_st_q <= ST_NOT_ALLOC;
							state_q  <= S_RES;
						end else begin
							own_vld_q[oidx] <= 1'b0;
							state_q         <= S_FOWN;
						end
					end
				end
				S_SRCH: begin
					if (j_q > eff_u) begin
						res_st_q <= ST_NO_SPACE;
						state_q  <= S_RES;
					end else if (head_j != NIL) begin
						b_q     <= head_j[UNIT_W-1:0];
						state_q <= S_ARM;
					end else begin
						j_q <= j_q + ORD_W'(1);
					end
				end
				S_ARM: begin
					if (pv_rd_q == NIL) begin
						head_q[j_q] <= nx_rd_q;
					end
					state_q <= (j_q > k_q) ? S_SPL0 : S_AFIN;
				end
				S_SPL0: begin
					j_q     <= jm1;
					r_q     <= r_c;
					h_q     <= head_jm1;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					head_q[j_q] <= LINK_W'(r_q);
					if (mode_t'(mode_q) == MODE_FREE) begin
						state_q <= S_RES;
					end else begin
						state_q <= (j_q > k_q) ? S_SPL0 : S_AFIN;
					end
				end
				S_AFIN: begin
					own_vld_q[oidx] <= 1'b1;
					res_st_q        <= ST_OK;
					res_off_q       <= unit_off(b_q, eff_l);
					res_ord_q       <= BORD_W'(k_q);
					state_q         <= S_RES;
				end
				S_FOWN: begin
					b_q       <= own_rd_q[UNIT_W-1:0];
					j_q       <= ORD_W'(own_rd_q[OWN_W-1:UNIT_W]) + eff_l;
					res_st_q  <= ST_OK;
					res_off_q <= unit_off(own_rd_q[UNIT_W-1:0], eff_l);
					res_ord_q <= BORD_W'(ORD_W'(own_rd_q[OWN_W-1:UNIT_W]) + eff_l);
					state_q   <= S_FTAG;
				end
				S_FTAG: begin
					if (j_q >= eff_u) begin
						state_q <= S_FFIN0;
					end else begin
						bud_q   <= bud_c;
						state_q <= S_FCMP;
					end
				end
				S_FCMP: begin
					state_q <= (tag_rd_q == {1'b1, rel_j}) ? S_FRM : S_FFIN0;
				end
				S_FRM: begin
					if (pv_rd_q == NIL) begin
						head_q[j_q] <= nx_rd_q;
					end
					b_q     <= (bud_q < b_q) ? bud_q : b_q;
					j_q     <= j_q + ORD_W'(1);
					state_q <= S_FTAG;
				end
				S_FFIN0: begin
					r_q     <= b_q;
					h_q     <= head_j;
					state_q <= S_PUSH;
				end
				S_RES: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_st_q;
						offset_q    <= res_off_q;
						order_q     <= res_ord_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE) || clr_q;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign block_offset = offset_q;
	assign block_order  = order_q;
	assign pready       = 1'b1;
	assign prdata       = (reg_sel_t'(paddr[2]) == REG_LOWER) ? DATA_W'(lower_q)
	                                                         : DATA_W'(upper_q);

endmodule

FILE: rtl/bba_checker.sv
// port-level checks for the buddy block allocator, bound to the top level
module bba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [2:0]                  status,
	input logic [bba_pkg::OFF_W-1:0]   block_offset,
	input logic [bba_pkg::BORD_W-1:0]  block_order
);
	import bba_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_offset)
			&& $stable(block_order))
		else $error("stalled result changed");

	// one request in flight
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in flight");

	// fault results carry no block
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(ST_OK) |-> block_offset == '0 && block_order == '0)
		else $error("fault result carries a block");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == 3'(ST_OK) || status == 3'(ST_NO_SPACE)
			|| status == 3'(ST_TOO_BIG) || status == 3'(ST_NOT_ALLOC)
			|| status == 3'(ST_ALREADY))
		else $error("unknown status code");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.block_offset (block_offset),
	.block_order  (block_order)
);

FILE: test/testbench.sv
// self-checking testbench for the buddy block allocator top level
module testbench;
	import bba_pkg::*;

	localparam int NUNITS = 1 << MAX_SPAN_C;
	localparam int NIL = NUNITS;
	localparam int LIMIT = 3000000;

	typedef struct {
		mode_t m;
		logic [ID_W-1:0] id;
		logic [SIZE_W-1:0] sz;
	} req_t;

	typedef struct {
		status_t st;
		logic [OFF_W-1:0] off;
		logic [BORD_W-1:0] ord;
	} grant_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	mode_t mode;
	logic [ID_W-1:0] owner_id;
	logic [SIZE_W-1:0] request_size;
	logic out_valid, out_stall;
	logic [2:0] status;
	logic [OFF_W-1:0] block_offset;
	logic [BORD_W-1:0] block_order;

	req_t request_q[$];
	grant_t grant_q[$];
	int send_idle, recv_idle;
	int fails;
	int cycles;

	// allocator shadow state
	int cfg_upper, cfg_lower, pool_u, pool_l;
	int free_head[MAX_ORDER_C+1];
	int link_nxt[NUNITS];
	int link_prv[NUNITS];
	logic [5:0] unit_tag[NUNITS];
	bit own_valid[MAX_OWNERS_C];
	int own_unit[MAX_OWNERS_C];
	int own_ord[MAX_OWNERS_C];

	buddy_block_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .owner_id(owner_id), .request_size(request_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .block_offset(block_offset), .block_order(block_order)
	);

	function automatic void push_free(int ord, int unit);
		int h;
		h = free_head[ord];
		link_nxt[unit] = h;
		link_prv[unit] = NIL;
		if (h != NIL)
			link_prv[h] = unit;
		free_head[ord] = unit;
	endfunction

	function automatic void unlink_free(int ord, int unit);
		int p, n;
		p = link_prv[unit];
		n = link_nxt[unit];
		if (p == NIL)
			free_head[ord] = n;
		else
			link_nxt[p] = n;
		if (n != NIL)
			link_prv[n] = p;
	endfunction

	function automatic void format_shadow();
		pool_u = cfg_upper > MAX_ORDER_C ? MAX_ORDER_C : cfg_upper;
		pool_l = cfg_lower;
		if (pool_u > MAX_SPAN_C && pool_l < pool_u - MAX_SPAN_C)
			pool_l = pool_u - MAX_SPAN_C;
		if (pool_l > pool_u)
			pool_l = pool_u;
		for (int i = 0; i <= MAX_ORDER_C; i++)
			free_head[i] = NIL;
		for (int i = 0; i < NUNITS; i++)
			unit_tag[i] = '0;
		for (int i = 0; i < MAX_OWNERS_C; i++)
			own_valid[i] = 0;
		unit_tag[0] = {1'b1, 5'(pool_u - pool_l)};
		push_free(pool_u, 0);
	endfunction

	function automatic grant_t serve_request(req_t r);
		grant_t g;
		int k, j, b, o, bud, rr, id;
		g.st = ST_OK;
		g.off = '0;
		g.ord = '0;
		id = r.id;
		if (r.m == MODE_ALLOC) begin
			if (own_valid[id]) begin
				g.st = ST_ALREADY;
			end else begin
				k = pool_l;
				while (k < 40 && (64'd1 << k) < 64'(r.sz))
					k++;
				if (k > pool_u) begin
					g.st = ST_TOO_BIG;
				end else begin
					j = k;
					while (j <= pool_u && free_head[j] == NIL)
						j++;
					if (j > pool_u) begin
						g.st = ST_NO_SPACE;
					end else begin
						b = free_head[j];
						unlink_free(j, b);
						while (j > k) begin
							j--;
							rr = (b + (1 << (j - pool_l))) & (NUNITS - 1);
							unit_tag[rr] = {1'b1, 5'(j - pool_l)};
							push_free(j, rr);
						end
						unit_tag[b] = {1'b0, 5'(k - pool_l)};
						own_valid[id] = 1;
						own_unit[id] = b;
						own_ord[id] = k;
						g.off = OFF_W'(b << pool_l);
						g.ord = BORD_W'(k);
					end
				end
			end
		end else begin
			if (!own_valid[id]) begin
				g.st = ST_NOT_ALLOC;
			end else begin
				b = own_unit[id];
				o = own_ord[id];
				own_valid[id] = 0;
				g.off = OFF_W'(b << pool_l);
				g.ord = BORD_W'(o);
				while (o < pool_u) begin
					bud = (b ^ (1 << (o - pool_l))) & (NUNITS - 1);
					if (unit_tag[bud] != {1'b1, 5'(o - pool_l)})
						break;
					unlink_free(o, bud);
					unit_tag[bud] = '0;
					unit_tag[b] = '0;
					if (bud < b)
						b = bud;
					o++;
				end
				unit_tag[b] = {1'b1, 5'(o - pool_l)};
				push_free(o, b);
			end
		end
		return g;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			mode <= MODE_ALLOC;
			owner_id <= '0;
			request_size <= '0;
		end else begin
			if (in_valid && !in_stall)
				grant_q.push_back(serve_request('{mode, owner_id, request_size}));
			if (!in_valid || !in_stall) begin
				if (request_q.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
					req_t r;
					r = request_q.pop_front();
					in_valid <= 1;
					mode <= r.m;
					owner_id <= r.id;
					request_size <= r.sz;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (grant_q.size() == 0) begin
					$display("%0t unexpected result status=%0d", $time, status);
					fails++;
				end else begin
					grant_t g;
					g = grant_q.pop_front();
					if (status !== g.st) begin
						$display("%0t status exp %0d got %0d", $time, g.st, status);
						fails++;
					end
					if (block_offset !== g.off) begin
						$display("%0t offset exp %0h got %0h", $time, g.off, block_offset);
						fails++;
					end
					if (block_order !== g.ord) begin
						$display("%0t order exp %0d got %0d", $time, g.ord, block_order);
						fails++;
					end
				end
			end
			out_stall <= ($urandom_range(99, 0) < recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("buddy_block_allocator_top regression: fail");
			$finish;
		end
	end

	task automatic add_req(mode_t m, int id, int sz);
		request_q.push_back('{m, ID_W'(id), SIZE_W'(sz)});
	endtask

	task automatic add_random(int n);
		int id, sz, pick;
		for (int i = 0; i < n; i++) begin
			id = ($urandom_range(99, 0) < 80) ? $urandom_range(11, 0) : $urandom_range(63, 0);
			pick = $urandom_range(99, 0);
			if (pick < 70)
				sz = $urandom_range(1 << pool_u, 0);
			else if (pick < 90)
				sz = $urandom_range(1 << pool_l, 0);
			else
				sz = $urandom_range((1 << SIZE_W) - 1, 0);
			add_req(($urandom_range(99, 0) < 55) ? MODE_ALLOC : MODE_FREE, id, sz);
		end
	endtask

	task automatic drain();
		while (request_q.size() > 0 || in_valid || grant_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(reg_sel_t idx, int value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_UPPER)
			cfg_upper = value & 31;
		else
			cfg_lower = value & 31;
		format_shadow();
	endtask

	task automatic run_phase(int upper, int lower, int n, int s_idle, int r_idle);
		write_reg(REG_UPPER, upper);
		write_reg(REG_LOWER, lower);
		send_idle = s_idle;
		recv_idle = r_idle;
		add_random(n);
		drain();
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		fails = 0;
		cycles = 0;
		send_idle = 36;
		recv_idle = 88;
		cfg_upper = UPPER_RST;
		cfg_lower = LOWER_RST;
		format_shadow();
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed part on the reset geometry
		add_req(MODE_ALLOC, 0, 0);
		add_req(MODE_ALLOC, 1, 1048576);
		add_req(MODE_ALLOC, 2, (1 << SIZE_W) - 1);
		add_req(MODE_ALLOC, 0, 5);
		add_req(MODE_FREE, 5, 0);
		add_req(MODE_FREE, 0, 0);
		add_req(MODE_ALLOC, 63, 1048576);
		add_req(MODE_ALLOC, 62, 1);
		add_req(MODE_FREE, 63, 0);
		add_req(MODE_ALLOC, 10, 1024);
		add_req(MODE_ALLOC, 11, 1025);
		add_req(MODE_ALLOC, 12, 4000);
		add_req(MODE_ALLOC, 13, 1000);
		add_req(MODE_FREE, 11, (1 << SIZE_W) - 1);
		add_req(MODE_FREE, 10, 0);
		add_req(MODE_FREE, 13, 0);
		add_req(MODE_FREE, 12, 0);
		add_req(MODE_ALLOC, 42, 524288);
		add_req(MODE_ALLOC, 21, 524288);
		add_req(MODE_ALLOC, 22, 1);
		add_req(MODE_FREE, 21, 0);
		add_req(MODE_FREE, 42, 0);
		add_random(100);
		drain();
		add_random(100);
		drain();

		run_phase(4, 0, 300, 36, 88);
		run_phase(1, 0, 150, 36, 88);
		run_phase(31, 20, 100, 88, 36);
		run_phase(12, 3, 300, 88, 36);
		run_phase(20, 0, 300, 88, 36);
		run_phase(8, 31, 100, 0, 0);
		run_phase(16, 9, 150, 0, 0);

		if (fails == 0)
			$display("buddy_block_allocator_top regression: pass");
		else
			$display("buddy_block_allocator_top regression: fail");
		$finish;
	end
endmodule

FILE: files.f
rtl/bba_pkg.sv
rtl/buddy_block_allocator_top.sv
rtl/bba_checker.sv
test/testbench.sv
